@@ sv/lsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsc_pkg
// Outcode bits, register indexes and limits for the line segment clipper.
// ----------------------------------------------------------------------------
package lsc_pkg;

  // Outcode bits for a point outside the clip rectangle.
  localparam logic [3:0] CODE_TOP    = 4'd8;
  localparam logic [3:0] CODE_BOTTOM = 4'd4;
  localparam logic [3:0] CODE_RIGHT  = 4'd2;
  localparam logic [3:0] CODE_LEFT   = 4'd1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  // Clip passes allowed before a segment is rejected.
  localparam logic [3:0] MAX_PASSES = 4'd8;

endpackage

@@ sv/lsc_muldiv.sv @@
// ----------------------------------------------------------------------------
// lsc_muldiv
// Bit-serial unit for floor(m * a / d) with a <= d, one bit of m per cycle.
// ----------------------------------------------------------------------------
module lsc_muldiv #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] m,
  input  logic [W-1:0] a,
  input  logic [W-1:0] d,
  output logic         done,
  output logic [W-1:0] q
);

  localparam int CW = (W > 1) ? $clog2(W) : 1;

  logic          running;
  logic [CW-1:0] bit_idx;
  logic [W-1:0]  m_reg;
  logic [W-1:0]  a_reg;
  logic [W-1:0]  d_reg;
  logic [W:0]    r;
  logic [W:0]    r_next;
  logic [W-1:0]  q_next;
  logic [W:0]    r_shift;
  logic [W-1:0]  q_shift;

  // One step: shift in a zero, reduce, add a when this bit of m is set, reduce.
  always_comb begin
    r_shift = {r[W-1:0], 1'b0};
    q_shift = {q[W-2:0], 1'b0};
    if (r_shift >= {1'b0, d_reg}) begin
      r_shift = r_shift - {1'b0, d_reg};
      q_shift = q_shift + W'(1);
    end
    r_next = r_shift;
    q_next = q_shift;
    if (m_reg[bit_idx]) begin
      r_next = r_shift + {1'b0, a_reg};
      if (r_next >= {1'b0, d_reg}) begin
        r_next = r_next - {1'b0, d_reg};
        q_next = q_shift + W'(1);
      end
    end
  end

  // Sequencing of the bit steps, most significant bit first.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go && !running) begin
        running <= 1'b1;
        bit_idx <= CW'(W - 1);
        m_reg   <= m;
        a_reg   <= a;
        d_reg   <= d;
        r       <= '0;
        q       <= '0;
      end else if (running) begin
        r <= r_next;
        q <= q_next;
        if (bit_idx == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          bit_idx <= bit_idx - CW'(1);
        end
      end
    end
  end

endmodule

@@ sv/line_segment_clipper.sv @@
// ----------------------------------------------------------------------------
// line_segment_clipper
// Cohen-Sutherland clipping of one segment against a configured rectangle.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  command   | start, busy            | start_x, start_y, end_x, end_y
//  result    | done (one-cycle)       | accepted, clipped_* coordinates
//  config    | psel, penable, pwrite  | paddr, pwdata, prdata (pready high)
//
// A transaction takes a decision step for each pass, a run of the shared
// bit-serial multiply-divide unit for each edge crossing, and a step to post
// the result. The divide unit steps one bit of the slope product a cycle.
// Reset is synchronous and restores the default rectangle.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module line_segment_clipper #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  output logic                          done,
  output logic                          accepted,
  output logic signed [COORD_WIDTH-1:0] clipped_start_x,
  output logic signed [COORD_WIDTH-1:0] clipped_start_y,
  output logic signed [COORD_WIDTH-1:0] clipped_end_x,
  output logic signed [COORD_WIDTH-1:0] clipped_end_y,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import lsc_pkg::*;

  localparam int W = COORD_WIDTH;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECIDE = 2'd1;
  localparam logic [1:0] ST_DIVIDE = 2'd2;

  logic [1:0] state;

  logic signed [W-1:0] x_min, y_min, x_max, y_max;
  logic signed [W-1:0] x1, y1, x2, y2;
  logic [3:0]          pass_cnt;

  // Saved context of the crossing under way.
  logic                move_start;
  logic                move_y_edge;
  logic                neg;
  logic signed [W-1:0] t_base;
  logic signed [W-1:0] edge_val;

  // Configuration port.
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_X_MIN: prdata = 32'(x_min);
      REG_Y_MIN: prdata = 32'(y_min);
      REG_X_MAX: prdata = 32'(x_max);
      REG_Y_MAX: prdata = 32'(y_max);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= W'(32);
      y_min <= W'(48);
      x_max <= W'(128);
      y_max <= W'(96);
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_X_MIN: x_min <= pwdata[W-1:0];
        REG_Y_MIN: y_min <= pwdata[W-1:0];
        REG_X_MAX: x_max <= pwdata[W-1:0];
        REG_Y_MAX: y_max <= pwdata[W-1:0];
        default:   ;
      endcase
    end
  end

  // Outcodes of the current endpoints; the minimum is tested first.
  logic [3:0] c1, c2, c_sel;

  always_comb begin
    c1 = '0;
    c2 = '0;
    if (x1 < x_min)      c1 = c1 | CODE_LEFT;
    else if (x1 > x_max) c1 = c1 | CODE_RIGHT;
    if (y1 < y_min)      c1 = c1 | CODE_BOTTOM;
    else if (y1 > y_max) c1 = c1 | CODE_TOP;
    if (x2 < x_min)      c2 = c2 | CODE_LEFT;
    else if (x2 > x_max) c2 = c2 | CODE_RIGHT;
    if (y2 < y_min)      c2 = c2 | CODE_BOTTOM;
    else if (y2 > y_max) c2 = c2 | CODE_TOP;
    c_sel = (c1 != '0) ? c1 : c2;
  end

  // Operands of the interpolation for the chosen edge.
  logic signed [W-1:0] t1_sel, t2_sel, s1_sel, s2_sel, edge_sel;
  logic                y_edge_sel;
  logic signed [W:0]   dt, da, dd;
  logic [W-1:0]        mag_dt, mag_a, mag_d, ua;

  always_comb begin
    y_edge_sel = 1'b1;
    t1_sel     = x1;
    t2_sel     = x2;
    s1_sel     = y1;
    s2_sel     = y2;
    edge_sel   = x_min;
    if ((c_sel & CODE_TOP) != '0) begin
      edge_sel = y_max;
    end else if ((c_sel & CODE_BOTTOM) != '0) begin
      edge_sel = y_min;
    end else begin
      y_edge_sel = 1'b0;
      t1_sel     = y1;
      t2_sel     = y2;
      s1_sel     = x1;
      s2_sel     = x2;
      edge_sel   = ((c_sel & CODE_RIGHT) != '0) ? x_max : x_min;
    end
    dt = (W+1)'(t2_sel) - (W+1)'(t1_sel);
    da = (W+1)'(edge_sel) - (W+1)'(s1_sel);
    dd = (W+1)'(s2_sel) - (W+1)'(s1_sel);
    mag_dt = dt[W] ? W'(-dt) : dt[W-1:0];
    mag_a  = da[W] ? W'(-da) : da[W-1:0];
    mag_d  = dd[W] ? W'(-dd) : dd[W-1:0];
    ua     = (mag_a > mag_d) ? mag_d : mag_a;
  end

  // Shared multiply-divide unit.
  logic         div_go;
  logic         div_done;
  logic [W-1:0] div_q;

  lsc_muldiv #(
    .W (W)
  ) u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .m    (mag_dt),
    .a    (ua),
    .d    (mag_d),
    .done (div_done),
    .q    (div_q)
  );

  logic decide_reject, decide_accept, decide_flat;

  always_comb begin
    decide_accept = (c1 == '0) && (c2 == '0);
    decide_reject = !decide_accept && (((c1 & c2) != '0) || (pass_cnt == MAX_PASSES));
    decide_flat   = (dd == '0);
    div_go        = (state == ST_DECIDE) && !decide_accept && !decide_reject && !decide_flat;
  end

  // New coordinate of the moved endpoint.
  logic signed [W:0] t_wide;
  logic signed [W-1:0] t_new;

  always_comb begin
    t_wide = neg ? ((W+1)'(t_base) - (W+1)'(div_q)) : ((W+1)'(t_base) + (W+1)'(div_q));
    t_new  = t_wide[W-1:0];
  end

  assign busy = (state != ST_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            x1       <= start_x;
            y1       <= start_y;
            x2       <= end_x;
            y2       <= end_y;
            pass_cnt <= '0;
            state    <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (decide_accept || decide_reject) begin
            done            <= 1'b1;
            accepted        <= decide_accept;
            clipped_start_x <= decide_accept ? x1 : '0;
            clipped_start_y <= decide_accept ? y1 : '0;
            clipped_end_x   <= decide_accept ? x2 : '0;
            clipped_end_y   <= decide_accept ? y2 : '0;
            state           <= ST_IDLE;
          end else if (decide_flat) begin
            // Zero span: the interpolated coordinate keeps its start value.
            pass_cnt <= pass_cnt + 4'd1;
            if (c1 != '0) begin
              if (y_edge_sel) begin x1 <= t1_sel; y1 <= edge_sel; end
              else            begin y1 <= t1_sel; x1 <= edge_sel; end
            end else begin
              if (y_edge_sel) begin x2 <= t1_sel; y2 <= edge_sel; end
              else            begin y2 <= t1_sel; x2 <= edge_sel; end
            end
          end else begin
            move_start  <= (c1 != '0);
            move_y_edge <= y_edge_sel;
            neg         <= dt[W] ^ da[W] ^ dd[W];
            t_base      <= t1_sel;
            edge_val    <= edge_sel;
            state       <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            pass_cnt <= pass_cnt + 4'd1;
            if (move_start) begin
              if (move_y_edge) begin x1 <= t_new; y1 <= edge_val; end
              else             begin y1 <= t_new; x1 <= edge_val; end
            end else begin
              if (move_y_edge) begin x2 <= t_new; y2 <= edge_val; end
              else             begin y2 <= t_new; x2 <= edge_val; end
            end
            state <= ST_DECIDE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ test/line_segment_clipper_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_segment_clipper_test
// Self-checking bench for the Cohen-Sutherland segment clipper. A queue of
// segments feeds a clocked driver and a clocked monitor checks each result
// against a local predictor. The clip rectangle is rewritten between phases
// over the register port.
// ----------------------------------------------------------------------------
module line_segment_clipper_test;
  import lsc_pkg::*;

  localparam int CW = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 8 * (CW + 2) + 10;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t sx, sy, ex, ey;
  } segment_t;

  typedef struct packed {
    logic   acc;
    coord_t sx, sy, ex, ey;
  } clip_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done, accepted, pready;
  coord_t start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  coord_t clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;

  // Rectangle as the bench believes it to be.
  longint win_x_min = 32, win_y_min = 48, win_x_max = 128, win_y_max = 96;

  segment_t     pending_segments[$];
  clip_result_t expected_clips[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           gap_left = 0;
  bit           timed_out = 1'b0;

  line_segment_clipper #(.COORD_WIDTH(CW)) u_dut (.*);

  // Clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES && !timed_out) begin
      timed_out = 1'b1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (x < win_x_min) c |= CODE_LEFT;
    else if (x > win_x_max) c |= CODE_RIGHT;
    if (y < win_y_min) c |= CODE_BOTTOM;
    else if (y > win_y_max) c |= CODE_TOP;
    return c;
  endfunction

  // Point on the segment at the given edge; quotient truncates toward zero.
  function automatic longint edge_cross(longint t1, longint t2, longint s1, longint s2,
                                        longint edge_pos);
    longint dt, a, d, ua, ud, q;
    dt = t2 - t1;
    a = edge_pos - s1;
    d = s2 - s1;
    if (d == 0) return t1;
    ua = (a < 0) ? -a : a;
    ud = (d < 0) ? -d : d;
    if (ua > ud) ua = ud;
    q = (((dt < 0) ? -dt : dt) * ua) / ud;
    return (((dt < 0) != (a < 0)) != (d < 0)) ? t1 - q : t1 + q;
  endfunction

  function automatic clip_result_t clip_segment(segment_t s);
    longint x1, y1, x2, y2, nx, ny;
    logic [3:0] c1, c2, c;
    clip_result_t r;
    bit ok;
    x1 = s.sx; y1 = s.sy; x2 = s.ex; y2 = s.ey;
    c1 = region_code(x1, y1);
    c2 = region_code(x2, y2);
    ok = 1'b0;
    for (int pass = 0; pass <= int'(MAX_PASSES); pass++) begin
      if (c1 == 0 && c2 == 0) begin
        ok = 1'b1;
        break;
      end
      if ((c1 & c2) != 0 || pass == int'(MAX_PASSES)) break;
      c = (c1 != 0) ? c1 : c2;
      if (c & CODE_TOP) begin
        nx = edge_cross(x1, x2, y1, y2, win_y_max); ny = win_y_max;
      end else if (c & CODE_BOTTOM) begin
        nx = edge_cross(x1, x2, y1, y2, win_y_min); ny = win_y_min;
      end else if (c & CODE_RIGHT) begin
        ny = edge_cross(y1, y2, x1, x2, win_x_max); nx = win_x_max;
      end else begin
        ny = edge_cross(y1, y2, x1, x2, win_x_min); nx = win_x_min;
      end
      if (c1 != 0) begin
        x1 = nx; y1 = ny; c1 = region_code(x1, y1);
      end else begin
        x2 = nx; y2 = ny; c2 = region_code(x2, y2);
      end
    end
    r.acc = ok;
    r.sx = ok ? coord_t'(x1) : '0;
    r.sy = ok ? coord_t'(y1) : '0;
    r.ex = ok ? coord_t'(x2) : '0;
    r.ey = ok ? coord_t'(y2) : '0;
    return r;
  endfunction

  // Driver: presents queued segments, with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // Transaction taken at this edge.
      expected_clips.push_back(clip_segment({start_x, start_y, end_x, end_y}));
      start <= 1'b0;
      gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) :
                  $urandom_range(0, 3);
    end else if (!start && gap_left > 0) begin
      gap_left <= gap_left - 1;
    end else if (!start && pending_segments.size() > 0) begin
      segment_t s;
      s = pending_segments.pop_front();
      start_x <= s.sx;
      start_y <= s.sy;
      end_x <= s.ex;
      end_y <= s.ey;
      start <= 1'b1;
    end
  end

  // Monitor: compares each result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      clip_result_t got, want;
      got = {accepted, clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y};
      if (expected_clips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = expected_clips.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected acc=%0b %0d %0d %0d %0d, got acc=%0b %0d %0d %0d %0d",
                     want.acc, want.sx, want.sy, want.ex, want.ey,
                     got.acc, got.sx, got.sy, got.ex, got.ey);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, coord_t value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{16{value[CW-1]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_X_MIN: win_x_min = value;
      REG_Y_MIN: win_y_min = value;
      REG_X_MAX: win_x_max = value;
      default:   win_y_max = value;
    endcase
  endtask

  task automatic set_window(coord_t xl, coord_t yl, coord_t xh, coord_t yh);
    write_reg(REG_X_MIN, xl);
    write_reg(REG_Y_MIN, yl);
    write_reg(REG_X_MAX, xh);
    write_reg(REG_Y_MAX, yh);
  endtask

  // Waits until every queued segment has been taken and every result seen.
  task automatic drain();
    while (pending_segments.size() > 0 || start || expected_clips.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    coord_t w;
    case (mode)
      0: w = coord_t'($urandom);
      1: w = coord_t'($signed($urandom_range(0, 400)) - 100);
      default: w = ($urandom_range(0, 1) == 0) ? coord_t'(16'sh8000) : coord_t'(16'sh7fff);
    endcase
    return w;
  endfunction

  // Mostly segments near the window, some from anywhere, a few at the extremes.
  task automatic queue_random(int count);
    segment_t s;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 6) ? 1 : (mode < 9) ? 0 : 2;
      s.sx = rand_coord(mode);
      s.sy = rand_coord(mode);
      s.ex = ($urandom_range(0, 3) == 0) ? rand_coord(2) : rand_coord(mode);
      s.ey = rand_coord(mode);
      pending_segments.push_back(s);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: default window, inside, trivial reject, each edge, extremes.
    pending_segments.push_back({16'sd40, 16'sd50, 16'sd120, 16'sd90});
    pending_segments.push_back({-16'sd10, 16'sd10, -16'sd5, 16'sd200});
    pending_segments.push_back({16'sd80, 16'sd200, 16'sd80, 16'sd60});
    pending_segments.push_back({16'sd80, -16'sd200, 16'sd80, 16'sd60});
    pending_segments.push_back({16'sd300, 16'sd70, 16'sd60, 16'sd70});
    pending_segments.push_back({-16'sd300, 16'sd70, 16'sd60, 16'sd70});
    pending_segments.push_back({16'sd0, 16'sd0, 16'sd200, 16'sd150});
    pending_segments.push_back({16'sd0, 16'sd150, 16'sd200, 16'sd0});
    pending_segments.push_back({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
    pending_segments.push_back({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
    pending_segments.push_back({16'sd0, 16'sd100, 16'sd40, 16'sd200});
    pending_segments.push_back({16'sd60, 16'sd60, 16'sd60, 16'sd60});
    queue_random(150);
    drain();

    // Full-range window.
    set_window(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    pending_segments.push_back({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    queue_random(80);
    drain();

    // Inverted window: passes may not settle.
    set_window(16'sd200, 16'sd150, 16'sd20, 16'sd10);
    pending_segments.push_back({16'sd100, 16'sd80, 16'sd100, 16'sd80});
    pending_segments.push_back({-16'sd50, -16'sd50, 16'sd300, 16'sd300});
    queue_random(80);
    drain();

    // Degenerate window: a single point.
    set_window(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    pending_segments.push_back({-16'sd10, -16'sd10, 16'sd10, 16'sd10});
    queue_random(60);
    drain();

    // Random windows.
    for (int k = 0; k < 4; k++) begin
      set_window(coord_t'($signed($urandom_range(0, 200)) - 150),
                 coord_t'($signed($urandom_range(0, 200)) - 150),
                 coord_t'($urandom_range(60, 300)), coord_t'($urandom_range(60, 300)));
      queue_random(35);
      drain();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
